[hdl/cppc_pkg.sv]
// Shared types and codes for the convex polygon point classifier.
// Used by the top level, its checker and the testbench; depends on nothing else.
`default_nettype none

package cppc_pkg;

  localparam int unsigned INDEX_BITS = 4;
  localparam int unsigned COUNT_BITS = 5;
  localparam int unsigned OUT_DATA_BITS = 8;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_POINT = 1'b1
  } func_t;

  typedef logic [1:0] place_t;

  localparam place_t PLACE_OUTSIDE = 2'd0;
  localparam place_t PLACE_PERIM   = 2'd1;
  localparam place_t PLACE_INSIDE  = 2'd2;

endpackage

`default_nettype wire

[hdl/convex_polygon_point_classifier_top.sv]
// Convex polygon point classifier: vertex table, sequencer and one shared multiplier.
// Depends on cppc_pkg.
//
// The slave stream carries one word per item. s_tuser selects a vertex load (0) or a
// point test (1); s_tlast marks the last point of a batch and comes back as m_tlast.
// A load writes one table entry in its accept cycle and gives no result. A point walks
// the vertices 0 to vertex_count-1 with one multiplier shared by both halves of each
// cross product: a table read, two multiplies and a sign test per vertex, then the
// word goes to the output register. A point holds s_tready low from its accept until
// its walk is done, its result word shows on the master side as s_tready returns,
// and no further point is taken during a walk. The count is capped at MAX_VERTICES;
// a negative product ends the walk early. The result sits in an output register, so
// the next item is taken while it waits; a further result waits in its last step
// until the master side has taken the first. The cfg channel writes vertex_count and
// is always ready; the user must write it only while the block is idle, which the
// block does not enforce. Reset clears vertex_count and the output valid flag; table
// entries hold no defined value until loaded, and no clearing pass runs.
`default_nettype none

module convex_polygon_point_classifier_top #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // s_tdata fields from bit 0: vertex_index, vertex_x, vertex_y, edge_dx, edge_dy,
  // point_x, point_y, zero fill.
  input  wire logic [((6*COORD_BITS+6+7)/8)*8-1:0]     s_tdata,
  input  wire logic                                    s_tuser,  // func
  input  wire logic                                    s_tlast,  // point_last
  input  wire logic                                    s_tvalid,
  output logic                                         s_tready,
  // m_tdata fields from bit 0: placement, strictly_inside, zero fill.
  output logic [cppc_pkg::OUT_DATA_BITS-1:0]           m_tdata,
  output logic                                         m_tlast,  // batch_end
  output logic                                         m_tvalid,
  input  wire logic                                    m_tready,
  input  wire logic [cppc_pkg::COUNT_BITS-1:0]         cfg_data,  // vertex_count
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready
);

  localparam int CB = COORD_BITS;
  localparam int EB = COORD_BITS + 1;
  localparam int PB = 2 * EB;
  localparam int XB = PB + 1;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int IW = $clog2(MAX_VERTICES + 1);
  localparam int ROW_BITS = 2 * CB + 2 * EB;

  localparam int VX_LO = cppc_pkg::INDEX_BITS;
  localparam int VY_LO = VX_LO + CB;
  localparam int EX_LO = VY_LO + CB;
  localparam int EY_LO = EX_LO + EB;
  localparam int PX_LO = EY_LO + EB;
  localparam int PY_LO = PX_LO + CB;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MULA,
    S_MULB,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state;

  logic [ROW_BITS-1:0] mem [MAX_VERTICES];
  logic [ROW_BITS-1:0] rd_row;

  logic [cppc_pkg::COUNT_BITS-1:0] vertex_count;
  logic [IW-1:0]                   n_eff;
  logic [IW-1:0]                   idx;
  logic [IW-1:0]                   idx_inc;
  logic signed [CB-1:0]            px;
  logic signed [CB-1:0]            py;
  logic                            last;
  logic                            outside;
  logic                            perim;
  logic signed [EB-1:0]            tx;
  logic signed [PB-1:0]            prod;
  logic signed [PB-1:0]            prod_a;
  logic signed [XB-1:0]            cross_val;
  logic signed [EB-1:0]            mul_a;
  logic signed [EB-1:0]            mul_b;
  logic signed [PB-1:0]            mul_p;
  logic signed [CB-1:0]            row_vx;
  logic signed [CB-1:0]            row_vy;
  logic signed [EB-1:0]            row_ex;
  logic signed [EB-1:0]            row_ey;
  logic [cppc_pkg::INDEX_BITS-1:0] load_index;
  logic                            load_hit;
  logic                            s_take;
  cppc_pkg::place_t                place;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign s_take    = s_tvalid && s_tready;

  assign load_index = s_tdata[cppc_pkg::INDEX_BITS-1:0];
  assign load_hit   = (32'(load_index) < 32'(MAX_VERTICES));

  assign row_vx = $signed(rd_row[CB-1:0]);
  assign row_vy = $signed(rd_row[2*CB-1:CB]);
  assign row_ex = $signed(rd_row[2*CB+EB-1:2*CB]);
  assign row_ey = $signed(rd_row[ROW_BITS-1:2*CB+EB]);

  always_comb begin
    if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
      n_eff = IW'(MAX_VERTICES);
    end else begin
      n_eff = IW'(vertex_count);
    end
  end

  assign idx_inc = idx + IW'(1);

  // The shared multiplier: edge_dx * (py - vy) first, then edge_dy * (px - vx).
  always_comb begin
    if (state == S_MULA) begin
      mul_a = row_ex;
      mul_b = EB'(py) - EB'(row_vy);
    end else begin
      mul_a = row_ey;
      mul_b = tx;
    end
  end

  assign mul_p = PB'(mul_a) * PB'(mul_b);
  assign cross_val = XB'(prod_a) - XB'(prod);

  always_comb begin
    if (outside) begin
      place = cppc_pkg::PLACE_OUTSIDE;
    end else if (perim) begin
      place = cppc_pkg::PLACE_PERIM;
    end else begin
      place = cppc_pkg::PLACE_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take && (s_tuser == cppc_pkg::FUNC_LOAD) && load_hit) begin
      mem[AW'(load_index)] <= {s_tdata[PX_LO-1:EY_LO], s_tdata[EY_LO-1:EX_LO],
                               s_tdata[EX_LO-1:VY_LO], s_tdata[VY_LO-1:VX_LO]};
    end
    rd_row <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      vertex_count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_take && (s_tuser == cppc_pkg::FUNC_POINT)) begin
            px      <= $signed(s_tdata[PY_LO-1:PX_LO]);
            py      <= $signed(s_tdata[PY_LO+CB-1:PY_LO]);
            last    <= s_tlast;
            idx     <= '0;
            outside <= 1'b0;
            perim   <= 1'b0;
            if (n_eff == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_MULA;
        end
        S_MULA: begin
          prod  <= mul_p;
          tx    <= EB'(px) - EB'(row_vx);
          state <= S_MULB;
        end
        S_MULB: begin
          prod_a <= prod;
          prod   <= mul_p;
          state  <= S_CHECK;
        end
        S_CHECK: begin
          if (cross_val < 0) begin
            outside <= 1'b1;
            state   <= S_DONE;
          end else begin
            if (cross_val == 0) begin
              perim <= 1'b1;
            end
            if (idx_inc == n_eff) begin
              state <= S_DONE;
            end else begin
              idx   <= idx_inc;
              state <= S_FETCH;
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(cppc_pkg::OUT_DATA_BITS-3){1'b0}},
                         (place == cppc_pkg::PLACE_INSIDE), place};
            m_tlast  <= last;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/cppc_checker.sv]
// Port-level checks for the convex polygon point classifier, bound to its top level.
// Depends on cppc_pkg and convex_polygon_point_classifier_top.
`default_nettype none

module cppc_checker #(
  parameter int MAX_VERTICES = 16
) (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tuser,
  input wire logic                                s_tvalid,
  input wire logic                                s_tready,
  input wire logic [cppc_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  input wire logic                                m_tlast,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic                                cfg_ready
);

  localparam int TABLE_DEPTH = MAX_VERTICES;

  // No result word may appear in the cycle right after any word is taken.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid && TABLE_DEPTH > 0) |=> !m_tvalid)
    else $error("result appeared directly after an accepted word");

  // A point keeps the input side busy in the cycle after its accept.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == cppc_pkg::FUNC_POINT) |=> !s_tready)
    else $error("input ready during a point walk");

  // The strictly-inside flag agrees with the placement code, which is never unused.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[2] == (m_tdata[1:0] == cppc_pkg::PLACE_INSIDE)) &&
                  (m_tdata[1:0] != 2'd3)))
    else $error("placement and strictly-inside disagree");

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

  // No result is offered in the cycle after reset, and the cfg channel is ready.
  assert property (@(posedge clk)
    rst |=> (!m_tvalid && cfg_ready))
    else $error("output valid after reset");

endmodule

bind convex_polygon_point_classifier_top cppc_checker #(
  .MAX_VERTICES(MAX_VERTICES)
) u_cppc_checker (.*);

`default_nettype wire

[tb/tb_convex_polygon_point_classifier_top.sv]
// Self-checking testbench for the convex polygon point classifier: it loads polygons,
// sets the vertex count and checks every point verdict against its own predictor.
// Depends on cppc_pkg and convex_polygon_point_classifier_top.
`default_nettype none

module tb_convex_polygon_point_classifier_top;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS = 16;
  localparam int S_BITS = ((6*COORD_BITS+6+7)/8)*8;
  localparam int ITEM_GOAL = 900;
  localparam int DRAIN_CYCLES = 4*MAX_VERTICES+16;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    cppc_pkg::func_t   func;
    logic [3:0]        index;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [16:0] ex;
    logic signed [16:0] ey;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic              last;
  } stream_item_t;

  typedef struct packed {
    cppc_pkg::place_t place;
    logic   strict;
    logic   last;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [S_BITS-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic s_tlast = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [cppc_pkg::OUT_DATA_BITS-1:0] m_tdata;
  logic m_tlast;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [cppc_pkg::COUNT_BITS-1:0] cfg_data = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;

  convex_polygon_point_classifier_top #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_data(cfg_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
  );

  stream_item_t item_backlog[$];
  verdict_t pending_verdicts[$];
  stream_item_t cur_item;
  logic s_took = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int send_odds = 0;
  int recv_odds = 0;
  logic hold_request = 1'b0;
  logic hold_off = 1'b0;
  int mismatch_count = 0;
  int items_queued = 0;
  int quiet_cycles = 0;

  logic signed [15:0] corner_x[MAX_VERTICES];
  logic signed [15:0] corner_y[MAX_VERTICES];
  logic signed [16:0] side_x[MAX_VERTICES];
  logic signed [16:0] side_y[MAX_VERTICES];
  logic [cppc_pkg::COUNT_BITS-1:0] corner_count = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic verdict_t classify_point(stream_item_t it);
    verdict_t v;
    int n;
    longint dxp;
    longint dyp;
    longint cross_prod;
    logic outside;
    logic on_edge;
    n = (corner_count > MAX_VERTICES) ? MAX_VERTICES : int'(corner_count);
    outside = 1'b0;
    on_edge = 1'b0;
    for (int j = 0; j < n && !outside; j++) begin
      dxp = longint'($signed(it.px)) - longint'($signed(corner_x[j]));
      dyp = longint'($signed(it.py)) - longint'($signed(corner_y[j]));
      cross_prod = longint'($signed(side_x[j])) * dyp - longint'($signed(side_y[j])) * dxp;
      if (cross_prod < 0) begin
        outside = 1'b1;
      end else if (cross_prod == 0) begin
        on_edge = 1'b1;
      end
    end
    if (outside) begin
      v.place = cppc_pkg::PLACE_OUTSIDE;
    end else if (on_edge) begin
      v.place = cppc_pkg::PLACE_PERIM;
    end else begin
      v.place = cppc_pkg::PLACE_INSIDE;
    end
    v.strict = (v.place == cppc_pkg::PLACE_INSIDE);
    v.last = it.last;
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic push_load(int idx, int x, int y, int dx, int dy);
    stream_item_t it;
    logic [31:0] rnd;
    it.func = cppc_pkg::FUNC_LOAD;
    it.index = idx[3:0];
    it.vx = x[15:0];
    it.vy = y[15:0];
    it.ex = dx[16:0];
    it.ey = dy[16:0];
    rnd = $urandom();
    it.px = rnd[15:0];
    it.py = rnd[31:16];
    rnd = $urandom();
    it.last = rnd[0];
    item_backlog.push_back(it);
    items_queued++;
  endtask

  task automatic push_point(int x, int y);
    stream_item_t it;
    logic [31:0] rnd;
    it.func = cppc_pkg::FUNC_POINT;
    rnd = $urandom();
    it.index = rnd[3:0];
    it.vx = rnd[19:4];
    it.last = rnd[20];
    rnd = $urandom();
    it.vy = rnd[15:0];
    it.ex = rnd[31:15];
    rnd = $urandom();
    it.ey = rnd[16:0];
    it.px = x[15:0];
    it.py = y[15:0];
    item_backlog.push_back(it);
    items_queued++;
  endtask

  // The block is idle once nothing is queued, offered or owed, plus a full walk of margin.
  task automatic wait_drained();
    while (item_backlog.size() != 0 || s_tvalid || pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(int value);
    @(negedge clk);
    cfg_data <= value[cppc_pkg::COUNT_BITS-1:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin : drive_input
    stream_item_t nxt;
    logic give;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      give = 1'b0;
      nxt = cur_item;
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (send_odds != 0 && $urandom_range(send_odds - 1, 0) == 0) begin
        send_gap <= $urandom_range(3, 0);
      end else if (item_backlog.size() != 0) begin
        nxt = item_backlog.pop_front();
        give = 1'b1;
      end
      s_tvalid <= give;
      if (give) begin
        cur_item <= nxt;
        s_tdata <= {2'b00, nxt.py, nxt.px, nxt.ey, nxt.ex, nxt.vy, nxt.vx, nxt.index};
        s_tuser <= nxt.func;
        s_tlast <= nxt.last;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_tready <= 1'b0;
    end else if (recv_odds != 0 && $urandom_range(recv_odds - 1, 0) == 0) begin
      recv_gap <= $urandom_range(3, 0);
      m_tready <= 1'b0;
    end else begin
      m_tready <= !hold_off;
    end
  end

  initial begin
    wait (hold_request);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : watch_outputs
    verdict_t want;
    s_took <= s_tvalid && s_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("unexpected word", int'(m_tdata), -1);
        end else begin
          want = pending_verdicts.pop_front();
          if (m_tdata[1:0] !== want.place) begin
            report_mismatch("placement", int'(m_tdata[1:0]), int'(want.place));
          end
          if (m_tdata[2] !== want.strict) begin
            report_mismatch("strictly_inside", int'(m_tdata[2]), int'(want.strict));
          end
          if (m_tlast !== want.last) begin
            report_mismatch("batch_end", int'(m_tlast), int'(want.last));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        corner_count = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        if (cur_item.func == cppc_pkg::FUNC_LOAD) begin
          corner_x[cur_item.index] = cur_item.vx;
          corner_y[cur_item.index] = cur_item.vy;
          side_x[cur_item.index] = cur_item.ex;
          side_y[cur_item.index] = cur_item.ey;
        end else begin
          pending_verdicts.push_back(classify_point(cur_item));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_convex_polygon_point_classifier_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int vx_a[MAX_VERTICES];
    int vy_a[MAX_VERTICES];
    int n;
    int r;
    int lim;
    int cx;
    int cy;
    int off;
    int j;
    int ex;
    int ey;
    int points;
    int phase;
    int sel;
    logic [31:0] rnd;
    real ang;
    real two_pi;
    two_pi = 6.283185307179586;
    phase = 0;
    send_odds = 4;
    recv_odds = 4;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // With no vertices in use every point is strictly inside.
    push_point(-32768, 32767);
    push_point(32767, -32768);
    push_load(0, -32768, 32767, 65535, -65536);
    push_load(1, 32767, -32768, -65536, 65535);
    for (int k = 2; k < MAX_VERTICES; k++) begin
      rnd = $urandom();
      push_load(k, int'($signed(rnd[15:0])), int'($signed(rnd[31:16])),
                int'($signed(17'($urandom()))), int'($signed(17'($urandom()))));
    end
    wait_drained();
    write_count(1);
    push_point(-32768, 32767);
    push_point(32767, -32768);
    push_point(-32768, -32768);
    wait_drained();
    // A count above the table size walks the whole table.
    write_count(31);
    push_point(0, 0);
    push_point(-32768, 32767);

    while (items_queued < ITEM_GOAL) begin
      phase++;
      if (items_queued > ITEM_GOAL * 85 / 100) begin
        send_odds = 0;
        recv_odds = 0;
      end else begin
        sel = $urandom_range(2, 0);
        send_odds = (sel == 0) ? 0 : 3 * sel;
        sel = $urandom_range(2, 0);
        recv_odds = (sel == 0) ? 0 : 3 * sel;
      end
      if ($urandom_range(9, 0) == 0) begin
        // Broken sequences: arbitrary entries and points mixed under an arbitrary count.
        wait_drained();
        write_count($urandom_range(31, 0));
        points = $urandom_range(15, 5);
        for (int k = 0; k < points; k++) begin
          rnd = $urandom();
          if (rnd[0]) begin
            push_load(int'(rnd[4:1]), int'($signed(rnd[20:5])), int'($signed(16'($urandom()))),
                      int'($signed(17'($urandom()))), int'($signed(17'($urandom()))));
          end else begin
            push_point(int'($signed(rnd[16:1])), int'($signed(16'($urandom()))));
          end
        end
      end else begin
        n = ($urandom_range(3, 0) == 0) ? MAX_VERTICES : int'($urandom_range(MAX_VERTICES, 3));
        r = ($urandom_range(4, 0) == 0) ? int'($urandom_range(40, 4))
                                        : int'($urandom_range(32000, 4));
        lim = 32767 - r;
        cx = int'($urandom_range(2 * lim, 0)) - lim;
        cy = int'($urandom_range(2 * lim, 0)) - lim;
        for (int k = 0; k < n; k++) begin
          ang = two_pi * (real'(k) + real'($urandom_range(29, 0)) / 100.0) / real'(n);
          vx_a[k] = cx + $rtoi(real'(r) * $cos(ang));
          vy_a[k] = cy + $rtoi(real'(r) * $sin(ang));
        end
        for (int k = 0; k < n; k++) begin
          push_load(k, vx_a[k], vy_a[k], vx_a[(k + 1) % n] - vx_a[k],
                    vy_a[(k + 1) % n] - vy_a[k]);
        end
        wait_drained();
        if (n == MAX_VERTICES && $urandom_range(2, 0) == 0) begin
          write_count($urandom_range(31, MAX_VERTICES + 1));
        end else begin
          write_count(n);
        end
        points = int'($urandom_range(30, 8));
        if (phase >= 2 && !hold_request) begin
          // Hold the result side off for a long stretch while points keep coming.
          points = 40;
          hold_request = 1'b1;
        end
        off = r / 4;
        for (int k = 0; k < points; k++) begin
          sel = $urandom_range(9, 0);
          if (sel < 4) begin
            push_point(cx + int'($urandom_range(2 * off, 0)) - off,
                       cy + int'($urandom_range(2 * off, 0)) - off);
          end else if (sel < 7) begin
            j = $urandom_range(n - 1, 0);
            ex = vx_a[(j + 1) % n] - vx_a[j];
            ey = vy_a[(j + 1) % n] - vy_a[j];
            if (ex % 2 == 0 && ey % 2 == 0) begin
              push_point(vx_a[j] + ex / 2, vy_a[j] + ey / 2);
            end else begin
              push_point(vx_a[j], vy_a[j]);
            end
          end else begin
            rnd = $urandom();
            push_point(int'($signed(rnd[15:0])), int'($signed(rnd[31:16])));
          end
        end
      end
    end

    while (item_backlog.size() != 0 || s_tvalid) @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("tb_convex_polygon_point_classifier_top passed");
    end else begin
      $display("tb_convex_polygon_point_classifier_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
